[hw/rtl/nstp_pkg.sv]
// nstp_pkg: shared widths, codes, state encoding and status types of the
// nested section time profiler
// no dependencies
package nstp_pkg;

    // field widths of the channel beats and the config port
    localparam int REQ_W     = 2;
    localparam int SEC_W     = 4;
    localparam int TS_W      = 32;
    localparam int METRIC_W  = 4;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int DEPTH_W   = 8;

    // section layout
    localparam int MAP_PHASES_DEF = 6;
    localparam int FIXED_SECTIONS = 5;

    // report metric codes
    localparam int FRAME_METRIC_IDX = 0;
    localparam int FPS_METRIC_IDX   = 6;

    // fps numerator: frames * ticks_per_second * 100 + elapsed / 2
    localparam int PROD_W    = TS_W + CFG_W;
    localparam int FPS_NUM_W = 56;
    localparam logic [TS_W-1:0] FPS_CAP   = 32'd99999;
    localparam logic [6:0]      FPS_SCALE = 7'd100;

    // config reset values
    localparam logic [CFG_W-1:0] PERIOD_TICKS_RST = 16'd100;
    localparam logic [CFG_W-1:0] TPS_RST          = 16'd200;

    typedef enum logic [REQ_W-1:0] {
        REQ_SEC_BEGIN   = 2'd0,
        REQ_SEC_END     = 2'd1,
        REQ_FRAME_BEGIN = 2'd2,
        REQ_FRAME_END   = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD_TICKS  = 1'b0,
        CFG_TICKS_PER_SEC = 1'b1
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SEC_BEGIN,
        S_SEC_END,
        S_SEC_ADD,
        S_FRAME_BEGIN,
        S_FE_DIFF,
        S_FE_FSUM,
        S_FE_SECT,
        S_FE_COUNT,
        S_FE_CHECK,
        S_FE_CMP,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_DIV_START,
        S_DIV_WAIT,
        S_CLEAR
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[hw/rtl/nstp_req_if.sv]
// nstp_req_if: event channel (valid, ready, event payload)
// depends on nstp_pkg
interface nstp_req_if import nstp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [SEC_W-1:0]  section;
    logic [TS_W-1:0]   timestamp;

    modport source (output valid, req_type, section, timestamp, input ready);
    modport sink   (input valid, req_type, section, timestamp, output ready);
endinterface

[hw/rtl/nstp_res_if.sv]
// nstp_res_if: report channel (valid, ready, metric payload)
// depends on nstp_pkg
interface nstp_res_if import nstp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [METRIC_W-1:0] metric;
    logic [TS_W-1:0]     value;
    logic                last;

    modport source (output valid, metric, value, last, input ready);
    modport sink   (input valid, metric, value, last, output ready);
endinterface

[hw/rtl/nested_section_time_profiler_top.sv]
// nested_section_time_profiler_top: section and frame timing profiler
// depends on nstp_pkg, nstp_req_if, nstp_res_if, nstp_div
//
// usage
//   i_req carries one event per beat: section begin/end, frame begin, frame end,
//   each with the tick counter value. o_res carries report beats (metric, value,
//   last); a report is 7 + MAP_PHASES beats in increasing metric order, emitted
//   only by a frame end that closes an averaging period. i_cfg_* writes
//   period_ticks (index 0) and ticks_per_second (index 1); the user must write
//   them only while idle, the block itself does not enforce this.
// sequencing
//   one event at a time; i_req.ready is high only in idle. a frame end walks
//   the sections on the shared 32-bit adder; a report adds per metric one
//   division on the shared serial divider, sized by the 56-bit fps numerator.
// reset
//   synchronous active-low; all sums, depths and starts clear at once, config
//   returns to 100 / 200, no clearing pass.
// stall
//   o_res has an output register; a stalled receiver holds the division
//   result in the divider until the register frees, the sequencer waits.
module nested_section_time_profiler_top import nstp_pkg::*; #(
    parameter int MAP_PHASES = MAP_PHASES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    nstp_req_if.sink             i_req,
    nstp_res_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    localparam int NUM_SECTIONS = FIXED_SECTIONS + MAP_PHASES;
    localparam int NUM_METRICS  = NUM_SECTIONS + 2;
    localparam int SIDX_W       = $clog2(NUM_SECTIONS);
    localparam int MCNT_W       = ($clog2(NUM_METRICS) > METRIC_W) ?
                                  $clog2(NUM_METRICS) : METRIC_W;
    localparam logic [MCNT_W-1:0] M_FRAME = MCNT_W'(FRAME_METRIC_IDX);
    localparam logic [MCNT_W-1:0] M_FPS   = MCNT_W'(FPS_METRIC_IDX);
    localparam logic [MCNT_W-1:0] M_LAST  = MCNT_W'(NUM_METRICS - 1);
    localparam logic [SIDX_W-1:0] S_LAST  = SIDX_W'(NUM_SECTIONS - 1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    // config
    logic [CFG_W-1:0] r_period_ticks;
    logic [CFG_W-1:0] r_tps;

    // sequencer and latched event
    t_state           r_state, n_state;
    logic [SEC_W-1:0] r_sec;
    logic [TS_W-1:0]  r_ts;
    logic [TS_W-1:0]  r_tmp;
    logic [TS_W-1:0]  r_elapsed;
    logic [SIDX_W-1:0] r_idx;
    logic [MCNT_W-1:0] r_metric;
    logic             r_started;

    // profiler state
    logic [TS_W-1:0]    r_frame_start;
    logic [TS_W-1:0]    r_sec_start   [NUM_SECTIONS];
    logic [DEPTH_W-1:0] r_depth       [NUM_SECTIONS];
    logic [TS_W-1:0]    r_frame_sum   [NUM_SECTIONS];
    logic [TS_W-1:0]    r_period_sum  [NUM_SECTIONS];
    logic [TS_W-1:0]    r_frame_period_sum;
    logic [TS_W-1:0]    r_period_frames;
    logic [TS_W-1:0]    r_period_start;

    // fps numerator
    logic [PROD_W-1:0]    r_prod;
    logic [FPS_NUM_W-1:0] r_num;

    // output register
    logic                r_out_valid;
    logic [METRIC_W-1:0] r_out_metric;
    logic [TS_W-1:0]     r_out_value;
    logic                r_out_last;

    // shared adder and helpers
    logic [TS_W-1:0]   add_a, add_b, add_y;
    logic              add_sub;
    logic              in_accept;
    logic              sec_valid;
    logic [SIDX_W-1:0] sec_i;
    logic [TS_W-1:0]   cur_start;
    logic [DEPTH_W-1:0] cur_depth;
    logic [TS_W-1:0]   cur_fsum;
    logic [MCNT_W-1:0] rpt_m;
    logic [SIDX_W-1:0] sum_idx;
    logic [TS_W-1:0]   limit;
    logic              div_start;
    logic              out_load;
    logic [FPS_NUM_W-1:0] div_dvd;
    logic [TS_W-1:0]   div_dvs;
    logic [FPS_NUM_W-1:0] div_quo;
    t_div_stat         div_stat;
    logic [TS_W-1:0]   rpt_value;

    assign in_accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    assign sec_valid = (r_sec < SEC_W'(NUM_SECTIONS));
    assign sec_i     = r_sec[SIDX_W-1:0];
    assign cur_start = r_sec_start[sec_i];
    assign cur_depth = r_depth[sec_i];
    assign cur_fsum  = r_frame_sum[sec_i];

    // metric to section: fixed sections sit below fps, map phases above
    assign rpt_m   = (r_metric > M_FPS) ? (r_metric - MCNT_W'(2)) :
                                          (r_metric - MCNT_W'(1));
    assign sum_idx = (r_state == S_FE_SECT) ? r_idx : rpt_m[SIDX_W-1:0];

    assign limit = (r_period_ticks == '0) ? TS_W'(1) : TS_W'(r_period_ticks);

    assign add_y = add_a + (add_sub ? ~add_b : add_b) + TS_W'(add_sub);

    always_comb begin
        if (r_metric == M_FRAME) begin
            div_dvd = FPS_NUM_W'(r_frame_period_sum);
        end else if (r_metric == M_FPS) begin
            div_dvd = r_num;
        end else begin
            div_dvd = FPS_NUM_W'(r_period_sum[sum_idx]);
        end
        div_dvs = (r_metric == M_FPS) ? r_elapsed : r_period_frames;
    end

    // fps is capped, averages always fit 32 bits
    always_comb begin
        if (r_metric == M_FPS && div_quo > FPS_NUM_W'(FPS_CAP)) begin
            rpt_value = FPS_CAP;
        end else begin
            rpt_value = div_quo[TS_W-1:0];
        end
    end

    nstp_div #(
        .DVD_W (FPS_NUM_W),
        .DVS_W (TS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    case (t_req'(i_req.req_type))
                        REQ_SEC_BEGIN:   n_state = S_SEC_BEGIN;
                        REQ_SEC_END:     n_state = S_SEC_END;
                        REQ_FRAME_BEGIN: n_state = S_FRAME_BEGIN;
                        REQ_FRAME_END:   n_state = S_FE_DIFF;
                        default:         n_state = S_IDLE;
                    endcase
                end
            end
            S_SEC_BEGIN:   n_state = S_IDLE;
            S_SEC_END: begin
                if (sec_valid && cur_depth == DEPTH_W'(1)) begin
                    n_state = S_SEC_ADD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SEC_ADD:     n_state = S_IDLE;
            S_FRAME_BEGIN: n_state = S_IDLE;
            S_FE_DIFF:     n_state = S_FE_FSUM;
            S_FE_FSUM:     n_state = S_FE_SECT;
            S_FE_SECT: begin
                if (r_idx == S_LAST) begin
                    n_state = S_FE_COUNT;
                end
            end
            S_FE_COUNT:    n_state = S_FE_CHECK;
            S_FE_CHECK: begin
                n_state = r_started ? S_FE_CMP : S_IDLE;
            end
            S_FE_CMP: begin
                if (r_elapsed < limit) begin
                    n_state = S_IDLE;
                end else if (r_period_frames == '0) begin
                    n_state = S_CLEAR;
                end else begin
                    n_state = S_DIV_START;
                end
            end
            S_MUL1:        n_state = S_MUL2;
            S_MUL2:        n_state = S_MUL3;
            S_MUL3:        n_state = S_DIV_START;
            S_DIV_START:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (out_load) begin
                    if (r_metric == M_LAST) begin
                        n_state = S_CLEAR;
                    end else if (r_metric + MCNT_W'(1) == M_FPS) begin
                        n_state = S_MUL1;
                    end else begin
                        n_state = S_DIV_START;
                    end
                end
            end
            S_CLEAR:       n_state = S_IDLE;
            default:       n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: shared adder operands, divider start, output load
    always_comb begin
        add_a     = '0;
        add_b     = '0;
        add_sub   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_SEC_END: begin
                add_a   = r_ts;
                add_b   = cur_start;
                add_sub = 1'b1;
            end
            S_SEC_ADD: begin
                add_a = cur_fsum;
                add_b = r_tmp;
            end
            S_FE_DIFF: begin
                add_a   = r_ts;
                add_b   = r_frame_start;
                add_sub = 1'b1;
            end
            S_FE_FSUM: begin
                add_a = r_frame_period_sum;
                add_b = r_tmp;
            end
            S_FE_SECT: begin
                add_a = r_period_sum[sum_idx];
                add_b = r_frame_sum[r_idx];
            end
            S_FE_COUNT: begin
                add_a = r_period_frames;
                add_b = TS_W'(1);
            end
            S_FE_CHECK: begin
                add_a   = r_ts;
                add_b   = r_period_start;
                add_sub = 1'b1;
            end
            S_DIV_START: div_start = 1'b1;
            S_DIV_WAIT:  out_load  = div_stat.done && (!r_out_valid || o_res.ready);
            default: begin
                add_sub = 1'b0;
            end
        endcase
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_ticks <= PERIOD_TICKS_RST;
            r_tps          <= TPS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PERIOD_TICKS:  r_period_ticks <= i_cfg_data;
                CFG_TICKS_PER_SEC: r_tps          <= i_cfg_data;
                default:           r_tps          <= r_tps;
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // latched event and scratch registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sec <= i_req.section;
            r_ts  <= i_req.timestamp;
        end
        case (r_state)
            S_SEC_END:  r_tmp     <= add_y;
            S_FE_DIFF:  r_tmp     <= add_y;
            S_FE_CHECK: r_elapsed <= add_y;
            S_FE_FSUM:  r_idx     <= '0;
            S_FE_SECT:  r_idx     <= r_idx + SIDX_W'(1);
            S_MUL1:     r_prod    <= PROD_W'(r_period_frames) * PROD_W'(r_tps);
            S_MUL2:     r_num     <= FPS_NUM_W'(r_prod) * FPS_NUM_W'(FPS_SCALE);
            S_MUL3:     r_num     <= r_num + FPS_NUM_W'(r_elapsed[TS_W-1:1]);
            default:    r_tmp     <= r_tmp;
        endcase
    end

    // profiler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_start      <= '0;
            r_frame_period_sum <= '0;
            r_period_frames    <= '0;
            r_period_start     <= '0;
            r_started          <= 1'b0;
            r_metric           <= '0;
            for (int i = 0; i < NUM_SECTIONS; i++) begin
                r_sec_start[i]  <= '0;
                r_depth[i]      <= '0;
                r_frame_sum[i]  <= '0;
                r_period_sum[i] <= '0;
            end
        end else begin
            case (r_state)
                S_SEC_BEGIN: begin
                    // only the outermost begin records a start, depth saturates
                    if (sec_valid) begin
                        if (cur_depth == '0) begin
                            r_sec_start[sec_i] <= r_ts;
                        end
                        if (cur_depth != DEPTH_MAX) begin
                            r_depth[sec_i] <= cur_depth + DEPTH_W'(1);
                        end
                    end
                end
                S_SEC_END: begin
                    // an end at depth zero is dropped
                    if (sec_valid && cur_depth != '0) begin
                        r_depth[sec_i] <= cur_depth - DEPTH_W'(1);
                    end
                end
                S_SEC_ADD: r_frame_sum[sec_i] <= add_y;
                S_FRAME_BEGIN: begin
                    r_frame_start <= r_ts;
                    for (int i = 0; i < NUM_SECTIONS; i++) begin
                        r_frame_sum[i] <= '0;
                    end
                end
                S_FE_FSUM:  r_frame_period_sum     <= add_y;
                S_FE_SECT:  r_period_sum[sum_idx]  <= add_y;
                S_FE_COUNT: r_period_frames        <= add_y;
                S_FE_CHECK: begin
                    // the first frame end opens the period and is not checked for a report
                    if (!r_started) begin
                        r_started      <= 1'b1;
                        r_period_start <= r_ts;
                    end
                end
                S_FE_CMP:   r_metric <= '0;
                S_DIV_WAIT: begin
                    if (out_load) begin
                        r_metric <= r_metric + MCNT_W'(1);
                    end
                end
                S_CLEAR: begin
                    r_frame_period_sum <= '0;
                    r_period_frames    <= '0;
                    r_period_start     <= r_ts;
                    for (int i = 0; i < NUM_SECTIONS; i++) begin
                        r_period_sum[i] <= '0;
                    end
                end
                default: r_metric <= r_metric;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_metric <= r_metric[METRIC_W-1:0];
            r_out_value  <= rpt_value;
            r_out_last   <= (r_metric == M_LAST);
        end
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.metric = r_out_metric;
    assign o_res.value  = r_out_value;
    assign o_res.last   = r_out_last;

    // divider is never restarted mid-division
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // report ends on the last metric
    a_last_metric: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.last) |-> (o_res.metric == M_LAST[METRIC_W-1:0]))
        else $error("last beat on wrong metric");

    // one event at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !i_req.ready)
        else $error("ready after accepted event");

    // output register loads only from a finished division
    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (div_stat.done && r_state == S_DIV_WAIT && !div_start))
        else $error("report beat without division result");

endmodule

[hw/rtl/nstp_div.sv]
// nstp_div: restoring radix-2 divider, one quotient bit per cycle
// depends on nstp_pkg
module nstp_div import nstp_pkg::*; #(
    parameter int DVD_W = FPS_NUM_W,
    parameter int DVS_W = TS_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output t_div_stat        o_stat,
    output logic [DVD_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;
    logic             ge;

    always_comb begin
        rem_sh  = {r_rem, r_quo[DVD_W-1]};
        ge      = (rem_sh >= {1'b0, r_dvs});
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath: dividend shifts out at the top, quotient bits in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], ge};
            r_rem <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;
endmodule
